@@ hdl/leb_pkg.sv @@
// leb_pkg: shared constants and types for the line edit buffer.
// Used by leb_ctrl, leb_datapath and line_edit_buffer; no dependencies.
package leb_pkg;

    // default capacity of the line, in characters
    localparam int BUF_SIZE_DEF = 64;

    // item field widths
    localparam int ACTION_W = 3;
    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 6;
    localparam int POS_W    = 7;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_BACKSPACE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_LEFT      = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_RIGHT     = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_READ      = 3'd6;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture the input item
        logic exec;    // apply the action to the line
        logic report;  // load the result register
    } ctrl_cmd_t;

endpackage

@@ hdl/leb_ctrl.sv @@
// leb_ctrl: sequencer of the line edit buffer (capture, execute, report)
// and owner of the result valid flag. Depends on leb_pkg.
module leb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output leb_pkg::ctrl_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_REPORT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    // result slot can take a new item when empty or draining this cycle
    assign slot_free = !out_valid_reg || m_axis_tready;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        s_axis_tready  = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_REPORT;
            end
            S_REPORT: begin
                if (slot_free) begin
                    cmd.report     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;

    a_take_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && s_axis_tvalid) |=> (state_reg == S_EXEC))
        else $error("accepted item did not move to execute");

    a_exec_then_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) |=> (state_reg == S_REPORT))
        else $error("execute step not followed by report");

    a_report_fills_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_REPORT && !out_valid_reg) |=> out_valid_reg)
        else $error("report into empty slot lost the result");

endmodule

@@ hdl/leb_datapath.sv @@
// leb_datapath: row of character cells, length and cursor registers,
// action decode and the result register. Depends on leb_pkg.
module leb_datapath #(
    parameter int BUF_SIZE = leb_pkg::BUF_SIZE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  leb_pkg::ctrl_cmd_t            cmd,
    input  logic [leb_pkg::ACTION_W-1:0]  action,
    input  logic [leb_pkg::CHAR_W-1:0]    char_in,
    input  logic [leb_pkg::INDEX_W-1:0]   read_index,
    output logic                          accepted,
    output logic [leb_pkg::POS_W-1:0]     cursor_pos,
    output logic [leb_pkg::POS_W-1:0]     line_length,
    output logic [leb_pkg::CHAR_W-1:0]    read_char
);

    localparam int CNT_W = $clog2(BUF_SIZE + 1);
    localparam int XW    = (CNT_W > leb_pkg::INDEX_W) ? CNT_W : leb_pkg::INDEX_W;
    localparam int NIDX  = 1 << leb_pkg::INDEX_W;

    // captured item
    logic [leb_pkg::ACTION_W-1:0] act_reg;
    logic [leb_pkg::CHAR_W-1:0]   char_reg;
    logic [leb_pkg::INDEX_W-1:0]  idx_reg;

    // line state
    logic [leb_pkg::CHAR_W-1:0] cell_reg [BUF_SIZE];
    logic [leb_pkg::CHAR_W-1:0] cell_next [BUF_SIZE];
    logic [CNT_W-1:0]           used_reg, used_next;
    logic [CNT_W-1:0]           cur_reg, cur_next;
    logic                       ok_reg, ok_next;

    logic             do_ins, do_rm;
    logic [CNT_W-1:0] rm_pos;

    // result register
    logic                        acc_reg;
    logic [leb_pkg::POS_W-1:0]   cpos_reg, len_reg;
    logic [leb_pkg::CHAR_W-1:0]  rchar_reg, rchar_next;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg  <= action;
            char_reg <= char_in;
            idx_reg  <= read_index;
        end
    end

    // action decode: new length, cursor and shift direction
    always_comb begin
        used_next = used_reg;
        cur_next  = cur_reg;
        ok_next   = 1'b0;
        do_ins    = 1'b0;
        do_rm     = 1'b0;
        rm_pos    = cur_reg;
        unique case (act_reg)
            leb_pkg::ACT_CLEAR: begin
                used_next = '0;
                cur_next  = '0;
                ok_next   = 1'b1;
            end
            leb_pkg::ACT_INSERT: begin
                if (used_reg < CNT_W'(BUF_SIZE)) begin
                    do_ins    = 1'b1;
                    used_next = used_reg + 1'b1;
                    cur_next  = cur_reg + 1'b1;
                    ok_next   = 1'b1;
                end
            end
            leb_pkg::ACT_DELETE: begin
                if (cur_reg < used_reg) begin
                    do_rm     = 1'b1;
                    used_next = used_reg - 1'b1;
                    ok_next   = 1'b1;
                end
            end
            leb_pkg::ACT_BACKSPACE: begin
                rm_pos = cur_reg - 1'b1;
                if (cur_reg != '0) begin
                    do_rm     = 1'b1;
                    used_next = used_reg - 1'b1;
                    cur_next  = cur_reg - 1'b1;
                    ok_next   = 1'b1;
                end
            end
            leb_pkg::ACT_LEFT: begin
                if (cur_reg != '0) begin
                    cur_next = cur_reg - 1'b1;
                    ok_next  = 1'b1;
                end
            end
            leb_pkg::ACT_RIGHT: begin
                if (cur_reg < used_reg) begin
                    cur_next = cur_reg + 1'b1;
                    ok_next  = 1'b1;
                end
            end
            leb_pkg::ACT_READ: begin
                ok_next = 1'b1;
            end
            default: begin
                ok_next = 1'b0;
            end
        endcase
    end

    // each cell takes its own value, its left or right neighbor, or the new
    // character; cells past the length may pick up garbage, never read
    always_comb begin
        for (int i = 0; i < BUF_SIZE; i++) begin
            cell_next[i] = cell_reg[i];
            if (do_ins) begin
                if (CNT_W'(i) == cur_reg) begin
                    cell_next[i] = char_reg;
                end else if (i > 0 && CNT_W'(i) > cur_reg) begin
                    cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
                end
            end else if (do_rm) begin
                if (i < BUF_SIZE - 1 && CNT_W'(i) >= rm_pos) begin
                    cell_next[i] = cell_reg[(i < BUF_SIZE - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            for (int i = 0; i < BUF_SIZE; i++) begin
                cell_reg[i] <= cell_next[i];
            end
            ok_reg <= ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            cur_reg  <= '0;
        end else if (cmd.exec) begin
            used_reg <= used_next;
            cur_reg  <= cur_next;
        end
    end

    // character read at the requested index, zero beyond the length
    always_comb begin
        rchar_next = '0;
        for (int i = 0; i < BUF_SIZE; i++) begin
            if (i < NIDX && idx_reg == leb_pkg::INDEX_W'(i)) begin
                rchar_next = cell_reg[i];
            end
        end
        if (XW'(idx_reg) >= XW'(used_reg)) begin
            rchar_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.report) begin
            acc_reg   <= ok_reg;
            cpos_reg  <= leb_pkg::POS_W'(cur_reg);
            len_reg   <= leb_pkg::POS_W'(used_reg);
            rchar_reg <= rchar_next;
        end
    end

    assign accepted    = acc_reg;
    assign cursor_pos  = cpos_reg;
    assign line_length = len_reg;
    assign read_char   = rchar_reg;

    a_cursor_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_reg <= used_reg)
        else $error("cursor beyond end of line");

    a_length_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(BUF_SIZE))
        else $error("line length beyond capacity");

endmodule

@@ hdl/line_edit_buffer.sv @@
// line_edit_buffer: command-line edit buffer with cursor, stream ports.
// Instantiates leb_ctrl and leb_datapath; depends on leb_pkg.
//
// Sequence: the item is captured, then applied in the execute step, and its
//   result is registered in the report step; the next item is taken only
//   after that report. The whole tail of the line shifts in the single
//   execute step. An unclaimed result stalls only the report step.
// Reset (aresetn low, synchronous): length, cursor, controller and result
//   valid cleared; character cells are not cleared and are never read
//   beyond the length.
module line_edit_buffer #(
    parameter int BUF_SIZE = leb_pkg::BUF_SIZE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input: action[2:0], char_in[10:3], read_index[16:11], zero pad above
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    // result: accepted[0], cursor_pos[7:1], line_length[14:8],
    //         read_char[22:15], zero pad above
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata
);

    leb_pkg::ctrl_cmd_t cmd;

    logic                          accepted;
    logic [leb_pkg::POS_W-1:0]     cursor_pos;
    logic [leb_pkg::POS_W-1:0]     line_length;
    logic [leb_pkg::CHAR_W-1:0]    read_char;

    // sequencer: one item in flight, result slot decoupled from input side
    leb_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd)
    );

    // line storage, edit logic and result register
    leb_datapath #(
        .BUF_SIZE (BUF_SIZE)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .action      (s_axis_tdata[2:0]),
        .char_in     (s_axis_tdata[10:3]),
        .read_index  (s_axis_tdata[16:11]),
        .accepted    (accepted),
        .cursor_pos  (cursor_pos),
        .line_length (line_length),
        .read_char   (read_char)
    );

    assign m_axis_tdata = {1'b0, read_char, line_length, cursor_pos, accepted};

endmodule
